// File: src/gsma_pkg.sv
`default_nettype none
package gsma_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int WINDOW            = 4;
    localparam int SLOT_W            = $clog2(WINDOW);
    localparam int RATE_BITS         = 16;
    localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd200;
    localparam int SPEED_BITS        = 40;
    localparam int SUM_BITS          = SPEED_BITS + $clog2(WINDOW);
    localparam int WIN_SHIFT         = $clog2(WINDOW);
    localparam int MAG_BITS          = SPEED_BITS + 1;
    localparam int SQ_DIGIT          = 8;
    localparam int SQ_STEPS          = (SPEED_BITS + SQ_DIGIT - 1) / SQ_DIGIT;
    localparam int SQ_IDX_W          = $clog2(SQ_STEPS);
    localparam int PART_BITS         = SPEED_BITS + SQ_DIGIT;
    localparam int ROOT_IN_BITS      = 2 * SPEED_BITS + 2;
    localparam int ROOT_STEPS        = MAG_BITS;
    localparam int CNT_W             = $clog2(ROOT_STEPS);
    localparam logic [ROOT_IN_BITS-1:0] ROOT_ONE_INIT =
        {2'b01, {(ROOT_IN_BITS-2){1'b0}}};
    localparam int OUT_RAW_BITS      = 2 * SPEED_BITS + MAG_BITS;
    localparam int OUT_DATA_W        = ((OUT_RAW_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                load;
        logic                speed;
        logic                window;
        logic                square;
        logic [SQ_IDX_W-1:0] sq_idx;
        logic                root;
        logic                out_load;
    } gsma_cmd_t;

endpackage
`default_nettype wire

// File: src/gps_speed_moving_average.sv
`default_nettype none
// Speed from successive position samples. Each item holds one signed x/y
// position; the block takes the absolute change on each axis, scales it by
// rate_scale (samples per second, 200 after reset; the user writes it on the
// cfg channel only while idle, which the block does not enforce), clamps each
// axis speed at 2^40-1, averages the last four speeds per axis (truncated) and
// returns both averages and the floor square root of their sum of squares as
// one result item. Previous position and the speed window start at zero after
// reset, so the first speed is |position| scaled. One item is in work at a
// time: after the idle step it passes the speed and window steps, the 5-step
// byte-serial squaring, the 41-step bit-serial square root and the output
// step, which waits while the output register holds an untaken result. A
// finished result waits in the output register while the next item is taken.
module gps_speed_moving_average
#(
    parameter int POSITION_BITS = gsma_pkg::POSITION_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [gsma_pkg::RATE_BITS-1:0]         cfg_data,        // rate_scale
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [((2*POSITION_BITS+7)/8)*8-1:0]   s_axis_tdata,    // pos_x, pos_y
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [gsma_pkg::OUT_DATA_W-1:0]             m_axis_tdata     // avg_speed_x,
                                                                         // avg_speed_y,
                                                                         // speed_magnitude
);
    import gsma_pkg::*;

    gsma_cmd_t                       cmd;
    logic signed [POSITION_BITS-1:0] pos_x, pos_y;

    assign cfg_ready = 1'b1;
    assign pos_x     = s_axis_tdata[POSITION_BITS-1:0];
    assign pos_y     = s_axis_tdata[2*POSITION_BITS-1:POSITION_BITS];

    gsma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    gsma_dp #(
        .POSITION_BITS (POSITION_BITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: src/gsma_ctrl.sv
`default_nettype none
module gsma_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output gsma_pkg::gsma_cmd_t     cmd
);
    import gsma_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SPEED  = 6'b000010,
        S_WIN    = 6'b000100,
        S_SQUARE = 6'b001000,
        S_ROOT   = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sq_idx     = cnt_reg[SQ_IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SPEED;
                end
            end
            S_SPEED:
            begin
                cmd.speed  = 1'b1;
                state_next = S_WIN;
            end
            S_WIN:
            begin
                cmd.window = 1'b1;
                cnt_next   = '0;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                if (cnt_reg == CNT_W'(SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                cmd.root = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: src/gsma_dp.sv
`default_nettype none
module gsma_dp
#(
    parameter int POSITION_BITS = gsma_pkg::POSITION_BITS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gsma_pkg::gsma_cmd_t                 cmd,
    input  wire logic                                cfg_valid,
    input  wire logic [gsma_pkg::RATE_BITS-1:0]      cfg_data,
    input  wire logic signed [POSITION_BITS-1:0]     pos_x,
    input  wire logic signed [POSITION_BITS-1:0]     pos_y,
    output logic [gsma_pkg::OUT_DATA_W-1:0]          out_data
);
    import gsma_pkg::*;

    localparam int DIFF_W = POSITION_BITS + 1;
    localparam int PROD_W = DIFF_W + RATE_BITS;

    logic [RATE_BITS-1:0]     rate_reg;
    logic [POSITION_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [DIFF_W-1:0]        dx_reg, dy_reg;
    logic [SPEED_BITS-1:0]    sp_x_reg, sp_y_reg;
    logic [SPEED_BITS-1:0]    win_x_reg [WINDOW];
    logic [SPEED_BITS-1:0]    win_y_reg [WINDOW];
    logic [SLOT_W-1:0]        slot_reg;
    logic [SUM_BITS-1:0]      sum_x_reg, sum_y_reg;
    logic [SPEED_BITS-1:0]    avg_x_reg, avg_y_reg;
    logic [ROOT_IN_BITS-1:0]  acc_reg, res_reg, one_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    logic [DIFF_W-1:0]        diff_x, diff_y, abs_x, abs_y;
    logic [PROD_W-1:0]        prod_x, prod_y;
    logic [SPEED_BITS-1:0]    speed_x, speed_y;
    logic [SUM_BITS-1:0]      sum_x_next, sum_y_next;
    logic [SLOT_W-1:0]        slot_next;
    logic [SQ_DIGIT-1:0]      dig_x, dig_y;
    logic [PART_BITS-1:0]     part_x, part_y;
    logic [ROOT_IN_BITS-1:0]  part_sum, trial;
    logic                     fits;

    assign diff_x = {pos_x[POSITION_BITS-1], pos_x} - {prev_x_reg[POSITION_BITS-1], prev_x_reg};
    assign diff_y = {pos_y[POSITION_BITS-1], pos_y} - {prev_y_reg[POSITION_BITS-1], prev_y_reg};
    assign abs_x  = diff_x[DIFF_W-1] ? ~diff_x + 1'b1 : diff_x;
    assign abs_y  = diff_y[DIFF_W-1] ? ~diff_y + 1'b1 : diff_y;

    assign prod_x = PROD_W'(dx_reg) * PROD_W'(rate_reg);
    assign prod_y = PROD_W'(dy_reg) * PROD_W'(rate_reg);

    // clamp at the top of the speed range
    always_comb
    begin
        if ((dx_reg >> SPEED_BITS) != '0 || (prod_x >> SPEED_BITS) != '0)
            speed_x = '1;
        else
            speed_x = SPEED_BITS'(prod_x);
        if ((dy_reg >> SPEED_BITS) != '0 || (prod_y >> SPEED_BITS) != '0)
            speed_y = '1;
        else
            speed_y = SPEED_BITS'(prod_y);
    end

    assign sum_x_next = sum_x_reg - SUM_BITS'(win_x_reg[slot_reg]) + SUM_BITS'(sp_x_reg);
    assign sum_y_next = sum_y_reg - SUM_BITS'(win_y_reg[slot_reg]) + SUM_BITS'(sp_y_reg);
    assign slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    assign dig_x    = SQ_DIGIT'(avg_x_reg >> (SQ_DIGIT * cmd.sq_idx));
    assign dig_y    = SQ_DIGIT'(avg_y_reg >> (SQ_DIGIT * cmd.sq_idx));
    assign part_x   = PART_BITS'(avg_x_reg) * PART_BITS'(dig_x);
    assign part_y   = PART_BITS'(avg_y_reg) * PART_BITS'(dig_y);
    assign part_sum = ROOT_IN_BITS'(part_x) + ROOT_IN_BITS'(part_y);

    assign trial = res_reg + one_reg;
    assign fits  = (acc_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_RESET;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            slot_reg   <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                rate_reg <= cfg_data;
            if (cmd.load)
            begin
                prev_x_reg <= pos_x;
                prev_y_reg <= pos_y;
            end
            if (cmd.window)
            begin
                sum_x_reg           <= sum_x_next;
                sum_y_reg           <= sum_y_next;
                win_x_reg[slot_reg] <= sp_x_reg;
                win_y_reg[slot_reg] <= sp_y_reg;
                slot_reg            <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg <= abs_x;
            dy_reg <= abs_y;
        end
        if (cmd.speed)
        begin
            sp_x_reg <= speed_x;
            sp_y_reg <= speed_y;
        end
        if (cmd.window)
        begin
            avg_x_reg <= SPEED_BITS'(sum_x_next >> WIN_SHIFT);
            avg_y_reg <= SPEED_BITS'(sum_y_next >> WIN_SHIFT);
            acc_reg   <= '0;
            res_reg   <= '0;
            one_reg   <= ROOT_ONE_INIT;
        end
        if (cmd.square)
            acc_reg <= acc_reg + (part_sum << (SQ_DIGIT * cmd.sq_idx));
        if (cmd.root)
        begin
            if (fits)
            begin
                acc_reg <= acc_reg - trial;
                res_reg <= (res_reg >> 1) + one_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
        if (cmd.out_load)
            out_data_reg <= OUT_DATA_W'({MAG_BITS'(res_reg), avg_y_reg, avg_x_reg});
    end

    assign out_data = out_data_reg;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gsma_pkg::*;

    localparam int POS_BITS = 32;
    localparam int SQ_W = 2 * SPEED_BITS + 2;
    localparam logic [63:0] SPEED_MAX = (64'd1 << SPEED_BITS) - 64'd1;

    typedef struct packed {
        logic [MAG_BITS-1:0]   mag;
        logic [SPEED_BITS-1:0] avg_y;
        logic [SPEED_BITS-1:0] avg_x;
    } speed_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [RATE_BITS-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [2*POS_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [2*POS_BITS-1:0] positions_to_send[$];
    speed_result_t speed_results_due[$];
    int unsigned fail_count = 0;

    // tracked block state
    logic [RATE_BITS-1:0]  rate_now = RATE_RESET;
    logic [POS_BITS-1:0]   last_x = '0;
    logic [POS_BITS-1:0]   last_y = '0;
    logic [SPEED_BITS-1:0] win_x[WINDOW] = '{default: '0};
    logic [SPEED_BITS-1:0] win_y[WINDOW] = '{default: '0};
    logic [SLOT_W-1:0]     slot = '0;
    logic [SUM_BITS-1:0]   sum_x = '0;
    logic [SUM_BITS-1:0]   sum_y = '0;

    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;

    always #5 clk = ~clk;

    gps_speed_moving_average dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int unsigned draw_gap(input bit calm);
        int unsigned pick;
        pick = $urandom_range(99);
        if (calm || pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 70);
    endfunction

    function automatic logic [SPEED_BITS-1:0] axis_speed(input logic [POS_BITS-1:0] cur,
                                                        input logic [POS_BITS-1:0] prev);
        logic signed [POS_BITS:0] delta;
        logic [63:0] prod;
        delta = {cur[POS_BITS-1], cur} - {prev[POS_BITS-1], prev};
        if (delta < 0)
            delta = -delta;
        prod = {{(63-POS_BITS){1'b0}}, delta} * {{(64-RATE_BITS){1'b0}}, rate_now};
        if (prod > SPEED_MAX)
            return SPEED_MAX[SPEED_BITS-1:0];
        return prod[SPEED_BITS-1:0];
    endfunction

    function automatic logic [MAG_BITS-1:0] floor_root(input logic [SPEED_BITS-1:0] ax,
                                                      input logic [SPEED_BITS-1:0] ay);
        logic [SQ_W-1:0] total;
        logic [SQ_W-1:0] trial_sq;
        logic [MAG_BITS-1:0] root;
        logic [MAG_BITS-1:0] trial;
        total = SQ_W'(ax) * SQ_W'(ax) + SQ_W'(ay) * SQ_W'(ay);
        root = '0;
        for (int b = MAG_BITS - 1; b >= 0; b--)
        begin
            trial = root | (MAG_BITS'(1) << b);
            trial_sq = SQ_W'(trial) * SQ_W'(trial);
            if (trial_sq <= total)
                root = trial;
        end
        return root;
    endfunction

    function automatic void advance_speed_window(input logic [POS_BITS-1:0] px,
                                                 input logic [POS_BITS-1:0] py);
        logic [SPEED_BITS-1:0] sx;
        logic [SPEED_BITS-1:0] sy;
        speed_result_t res;
        sx = axis_speed(px, last_x);
        sy = axis_speed(py, last_y);
        sum_x = sum_x - SUM_BITS'(win_x[slot]) + SUM_BITS'(sx);
        sum_y = sum_y - SUM_BITS'(win_y[slot]) + SUM_BITS'(sy);
        win_x[slot] = sx;
        win_y[slot] = sy;
        slot = slot + 1'b1;
        last_x = px;
        last_y = py;
        res.avg_x = sum_x[SUM_BITS-1:WIN_SHIFT];
        res.avg_y = sum_y[SUM_BITS-1:WIN_SHIFT];
        res.mag = floor_root(res.avg_x, res.avg_y);
        speed_results_due.push_back(res);
    endfunction

    // item source
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_speed_window(s_axis_tdata[POS_BITS-1:0],
                                     s_axis_tdata[2*POS_BITS-1:POS_BITS]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (positions_to_send.size() > 0)
                begin
                    s_axis_tdata <= positions_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(99) < 4)
                        send_calm = !send_calm;
                    send_gap = draw_gap(send_calm);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink and check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                speed_result_t got;
                speed_result_t want;
                got = m_axis_tdata[$bits(speed_result_t)-1:0];
                if (speed_results_due.size() == 0)
                begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = speed_results_due.pop_front();
                    if (got.avg_x !== want.avg_x)
                    begin
                        $error("avg_speed_x: expected %0d, got %0d", want.avg_x, got.avg_x);
                        fail_count++;
                    end
                    if (got.avg_y !== want.avg_y)
                    begin
                        $error("avg_speed_y: expected %0d, got %0d", want.avg_y, got.avg_y);
                        fail_count++;
                    end
                    if (got.mag !== want.mag)
                    begin
                        $error("speed_magnitude: expected %0d, got %0d", want.mag, got.mag);
                        fail_count++;
                    end
                end
                if ($urandom_range(99) < 4)
                    recv_calm = !recv_calm;
                recv_gap = draw_gap(recv_calm);
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (positions_to_send.size() != 0 || s_axis_tvalid ||
               speed_results_due.size() != 0);
    endtask

    task automatic write_rate(input logic [RATE_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rate_now = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic push_position(input logic [POS_BITS-1:0] px, input logic [POS_BITS-1:0] py);
        positions_to_send.push_back({py, px});
    endtask

    initial
    begin
        logic [POS_BITS-1:0] track_x;
        logic [POS_BITS-1:0] track_y;
        logic [RATE_BITS-1:0] phase_rate;
        int unsigned pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset rate: first sample, standstill, full-swing steps without saturation
        push_position(32'd1000, -32'sd1000);
        push_position(32'd1000, -32'sd1000);
        push_position(32'h7fff_ffff, 32'h8000_0000);
        push_position(32'h8000_0000, 32'h7fff_ffff);
        push_position(32'd0, 32'd0);
        push_position(32'hffff_ffff, 32'd1);
        push_position(32'd12345, -32'sd54321);
        wait_until_idle();

        write_rate(16'hffff);
        push_position(32'd0, 32'd0);
        push_position(32'd1, 32'hffff_ffff);
        push_position(32'h8000_0000, 32'h7fff_ffff);
        push_position(32'd0, 32'd0);
        wait_until_idle();

        write_rate(16'd0);
        push_position(32'd5, 32'd5);
        push_position(32'h8000_0000, 32'h7fff_ffff);
        wait_until_idle();

        write_rate(16'd1);
        push_position(32'd0, 32'd0);
        push_position(32'h7fff_ffff, 32'h7fff_ffff);
        push_position(32'h8000_0000, 32'h8000_0000);
        push_position(32'd0, 32'd0);
        push_position(32'd3, 32'd4);
        wait_until_idle();

        track_x = 32'h8000_0000;
        track_y = 32'h8000_0000;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: phase_rate = RATE_RESET;
                1: phase_rate = 16'hffff;
                2: phase_rate = 16'd1;
                default: phase_rate = RATE_BITS'($urandom_range(1, 65535));
            endcase
            write_rate(phase_rate);
            for (int n = 0; n < 105; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    track_x = track_x + 32'($urandom_range(0, 2000)) - 32'd1000;
                    track_y = track_y + 32'($urandom_range(0, 2000)) - 32'd1000;
                end
                else if (pick < 75)
                begin
                    track_x = track_x + 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
                    track_y = track_y + 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
                end
                else if (pick < 90)
                begin
                    track_x = $urandom();
                    track_y = $urandom();
                end
                else
                begin
                    track_x = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
                    track_y = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
                end
                push_position(track_x, track_y);
            end
            wait_until_idle();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0 && speed_results_due.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
